FILE: rtl/drone_id_tlv_beacon_parser_defines.svh
// ----------------------------------------------------------------------------
// Drone ID TLV beacon parser: assertion macros
// Shared concurrent assertion forms used by the RTL modules.
// ----------------------------------------------------------------------------
`ifndef DRONE_ID_TLV_BEACON_PARSER_DEFINES_SVH
`define DRONE_ID_TLV_BEACON_PARSER_DEFINES_SVH

// Condition must hold at every clock edge outside reset.
`define DTP_ASSERT_ALWAYS(label, clk, rst, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("assertion failed");

// Consequent must hold in the same cycle as the antecedent.
`define DTP_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

`endif

FILE: rtl/dtp_pkg.sv
// ----------------------------------------------------------------------------
// dtp_pkg
// Types and constants shared by the beacon parser front end, queue and back end.
// ----------------------------------------------------------------------------
package dtp_pkg;

  // frame layout
  localparam logic [8:0] FIRST_RECORD = 9'd6;
  localparam logic [8:0] LENGTH_BIAS  = 9'd2;

  // TLV tags carrying identifier strings
  localparam logic [7:0] TAG_OPERATOR = 8'd2;
  localparam logic [7:0] TAG_SERIAL   = 8'd3;

  // field store slots
  localparam int NUM_SLOTS = 8;
  localparam logic [2:0] SLOT_UAV_LAT   = 3'd0;
  localparam logic [2:0] SLOT_UAV_LON   = 3'd1;
  localparam logic [2:0] SLOT_ALT_MSL   = 3'd2;
  localparam logic [2:0] SLOT_HEIGHT    = 3'd3;
  localparam logic [2:0] SLOT_BASE_LAT  = 3'd4;
  localparam logic [2:0] SLOT_BASE_LON  = 3'd5;
  localparam logic [2:0] SLOT_SPEED     = 3'd6;
  localparam logic [2:0] SLOT_HEADING   = 3'd7;

  typedef enum logic [1:0] {
    KIND_OPERATOR = 2'd0,
    KIND_SERIAL   = 2'd1,
    KIND_SUMMARY  = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    ST_NONE,
    ST_CLEAR,
    ST_WRITE
  } store_op_t;

  // one classified input byte, as handed from front end to back end
  typedef struct packed {
    logic        clr_all;
    logic        has_char;
    kind_t       kind;
    logic [4:0]  char_index;
    logic [7:0]  data;
    store_op_t   st_op;
    logic [2:0]  slot;
    logic [1:0]  lane;
    logic        has_sum;
  } dtp_cmd_t;

endpackage

FILE: rtl/dtp_byte_if.sv
// ----------------------------------------------------------------------------
// dtp_byte_if
// Input channel: one beacon payload byte per item, valid/ready handshake.
// ----------------------------------------------------------------------------
interface dtp_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       frame_start;

  modport source (output valid, output data_byte, output frame_start, input ready);
  modport sink   (input valid, input data_byte, input frame_start, output ready);
endinterface

FILE: rtl/dtp_result_if.sv
// ----------------------------------------------------------------------------
// dtp_result_if
// Output channel: identifier characters and frame summaries, valid/ready.
// ----------------------------------------------------------------------------
interface dtp_result_if;
  logic               valid;
  logic               ready;
  logic [1:0]         kind;
  logic [4:0]         char_index;
  logic [7:0]         char_value;
  logic signed [31:0] uav_latitude;
  logic signed [31:0] uav_longitude;
  logic signed [15:0] sea_level_alt;
  logic signed [15:0] ground_height;
  logic signed [31:0] home_latitude;
  logic signed [31:0] home_longitude;
  logic [7:0]         ground_speed;
  logic [15:0]        course_heading;
  logic               last_of_run;

  modport source (
    output valid, output kind, output char_index, output char_value,
    output uav_latitude, output uav_longitude, output sea_level_alt, output ground_height,
    output home_latitude, output home_longitude, output ground_speed,
    output course_heading, output last_of_run, input ready
  );
  modport sink (
    input valid, input kind, input char_index, input char_value,
    input uav_latitude, input uav_longitude, input sea_level_alt, input ground_height,
    input home_latitude, input home_longitude, input ground_speed,
    input course_heading, input last_of_run, output ready
  );
endinterface

FILE: rtl/dtp_front.sv
// ----------------------------------------------------------------------------
// dtp_front
// Frame and TLV record tracking; turns each byte with a visible effect into one back end command.
// ----------------------------------------------------------------------------
module dtp_front import dtp_pkg::*; #(
  parameter int ID_CHARS = 20
) (
  input  logic           clk,
  input  logic           rst,
  dtp_byte_if.sink       beacon,
  input  logic           q_full,
  output logic           push,
  output dtp_cmd_t       push_cmd
);

  localparam logic [7:0] IdCharsW = 8'(ID_CHARS);

  typedef enum logic [1:0] {
    PH_TAG,
    PH_LEN,
    PH_VAL
  } phase_t;

  typedef struct packed {
    logic       valid;
    logic [2:0] slot;
    logic [2:0] width;
  } tag_info_t;

  function automatic tag_info_t tag_lookup(input logic [7:0] tag);
    tag_info_t r;
    r = '0;
    case (tag)
      8'd4:    r = '{1'b1, SLOT_UAV_LAT,  3'd4};
      8'd5:    r = '{1'b1, SLOT_UAV_LON,  3'd4};
      8'd6:    r = '{1'b1, SLOT_ALT_MSL,  3'd2};
      8'd7:    r = '{1'b1, SLOT_HEIGHT,   3'd2};
      8'd8:    r = '{1'b1, SLOT_BASE_LAT, 3'd4};
      8'd9:    r = '{1'b1, SLOT_BASE_LON, 3'd4};
      8'd10:   r = '{1'b1, SLOT_SPEED,    3'd1};
      8'd11:   r = '{1'b1, SLOT_HEADING,  3'd2};
      default: r = '0;
    endcase
    return r;
  endfunction

  logic [8:0] byte_position, byte_position_next;
  logic [8:0] frame_length, frame_length_next;
  logic [7:0] record_tag, record_tag_next;
  logic [7:0] record_remaining, record_remaining_next;
  phase_t     record_phase, record_phase_next;
  logic [7:0] value_byte_count, value_byte_count_next;

  // state as seen by this byte (frame start clears it first)
  logic [8:0] bp, fl;
  logic [7:0] tag, rem, cnt, b, rem_dec;
  phase_t     ph;
  logic       fs, accept, ignore;
  tag_info_t  info;
  dtp_cmd_t   cmd;

  assign beacon.ready = !q_full;
  assign accept       = beacon.valid && !q_full;

  always_comb begin
    fs   = beacon.frame_start;
    b    = beacon.data_byte;
    bp   = fs ? '0 : byte_position;
    fl   = fs ? '0 : frame_length;
    tag  = fs ? '0 : record_tag;
    rem  = fs ? '0 : record_remaining;
    ph   = fs ? PH_TAG : record_phase;
    cnt  = fs ? '0 : value_byte_count;
    info = tag_lookup(tag);
    rem_dec = rem - 8'd1;

    byte_position_next    = bp;
    frame_length_next     = fl;
    record_tag_next       = tag;
    record_remaining_next = rem;
    record_phase_next     = ph;
    value_byte_count_next = cnt;

    cmd         = '0;
    cmd.kind    = KIND_OPERATOR;
    cmd.st_op   = ST_NONE;
    cmd.clr_all = fs;
    cmd.data    = b;

    ignore = (bp >= 9'd2) && (bp >= fl);

    if (!ignore) begin
      if (bp == 9'd1) begin
        frame_length_next = {1'b0, b} + LENGTH_BIAS;
      end else if (bp >= FIRST_RECORD) begin
        case (ph)
          PH_TAG: begin
            record_tag_next   = b;
            record_phase_next = PH_LEN;
          end
          PH_LEN: begin
            if (info.valid) begin
              cmd.st_op = ST_CLEAR;
              cmd.slot  = info.slot;
            end
            record_remaining_next = b;
            value_byte_count_next = '0;
            record_phase_next     = (b == 8'd0) ? PH_TAG : PH_VAL;
          end
          PH_VAL: begin
            if ((tag == TAG_OPERATOR || tag == TAG_SERIAL) && cnt < IdCharsW) begin
              cmd.has_char   = 1'b1;
              cmd.kind       = (tag == TAG_OPERATOR) ? KIND_OPERATOR : KIND_SERIAL;
              cmd.char_index = cnt[4:0];
            end
            if (info.valid && cnt < {5'd0, info.width}) begin
              cmd.st_op = ST_WRITE;
              cmd.slot  = info.slot;
              cmd.lane  = 2'(info.width - 3'd1 - cnt[2:0]);
            end
            if (cnt != 8'hFF) value_byte_count_next = cnt + 8'd1;
            record_remaining_next = rem_dec;
            if (rem_dec == 8'd0) record_phase_next = PH_TAG;
          end
          default: record_phase_next = PH_TAG;
        endcase
      end
      // length byte 0 ends the frame on the length byte itself
      cmd.has_sum = (bp >= 9'd1) && ({1'b0, bp} + 10'd1 == {1'b0, frame_length_next});
      byte_position_next = bp + 9'd1;
    end
  end

  // only bytes with a visible effect go to the back end
  assign push     = accept && (cmd.clr_all || cmd.has_char || cmd.has_sum ||
                               cmd.st_op != ST_NONE);
  assign push_cmd = cmd;

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position    <= '0;
      frame_length     <= '0;
      record_tag       <= '0;
      record_remaining <= '0;
      record_phase     <= PH_TAG;
      value_byte_count <= '0;
    end else if (accept) begin
      byte_position    <= byte_position_next;
      frame_length     <= frame_length_next;
      record_tag       <= record_tag_next;
      record_remaining <= record_remaining_next;
      record_phase     <= record_phase_next;
      value_byte_count <= value_byte_count_next;
    end
  end

endmodule

FILE: rtl/dtp_queue.sv
// ----------------------------------------------------------------------------
// dtp_queue
// Small register FIFO of commands between front end and back end.
// ----------------------------------------------------------------------------
`include "drone_id_tlv_beacon_parser_defines.svh"

module dtp_queue import dtp_pkg::*; #(
  parameter int DEPTH = 4
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     push,
  input  dtp_cmd_t push_cmd,
  output logic     full,
  input  logic     pop,
  output dtp_cmd_t head_cmd,
  output logic     empty
);

  localparam int PtrW = $clog2(DEPTH);
  localparam int CntW = $clog2(DEPTH + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);
  localparam logic [CntW-1:0] DepthC  = CntW'(DEPTH);

  dtp_cmd_t        slots [DEPTH];
  logic [PtrW-1:0] wr_ptr, rd_ptr;
  logic [CntW-1:0] count;

  assign full     = (count == DepthC);
  assign empty    = (count == '0);
  assign head_cmd = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == LastPtr) ? '0 : wr_ptr + 1'b1;
      if (pop)  rd_ptr <= (rd_ptr == LastPtr) ? '0 : rd_ptr + 1'b1;
      if (push && !pop)      count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_cmd;
  end

  `DTP_ASSERT_IMPLIES(a_no_overflow, clk, rst, push, !full)
  `DTP_ASSERT_IMPLIES(a_no_underflow, clk, rst, pop, !empty)

endmodule

FILE: rtl/dtp_back.sv
// ----------------------------------------------------------------------------
// dtp_back
// Applies field store updates in order and emits character and summary items.
// ----------------------------------------------------------------------------
`include "drone_id_tlv_beacon_parser_defines.svh"

module dtp_back import dtp_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  dtp_cmd_t   head_cmd,
  input  logic       q_empty,
  output logic       pop,
  dtp_result_if.source result
);

  logic [31:0] store [NUM_SLOTS];
  logic [31:0] store_next [NUM_SLOTS];

  logic head_valid, can_load, retire, load, load_sum, last;
  logic phase, phase_next;    // 1: character sent, summary still due
  logic res_valid;

  assign head_valid = !q_empty;
  assign can_load   = !res_valid || result.ready;

  // store contents once the head command has been applied
  always_comb begin
    for (int i = 0; i < NUM_SLOTS; i++) begin
      store_next[i] = store[i];
      if (head_cmd.clr_all) begin
        store_next[i] = '0;
      end else if (head_cmd.slot == 3'(i)) begin
        if (head_cmd.st_op == ST_CLEAR) begin
          store_next[i] = '0;
        end else if (head_cmd.st_op == ST_WRITE) begin
          store_next[i][{head_cmd.lane, 3'b000} +: 8] = head_cmd.data;
        end
      end
    end
  end

  always_comb begin
    retire     = 1'b0;
    load       = 1'b0;
    load_sum   = 1'b0;
    last       = 1'b0;
    phase_next = phase;
    if (head_valid) begin
      if (!head_cmd.has_char && !head_cmd.has_sum) begin
        retire = 1'b1;
      end else if (can_load) begin
        load = 1'b1;
        if (head_cmd.has_char && !phase) begin
          last = !head_cmd.has_sum;
          if (head_cmd.has_sum) phase_next = 1'b1;
          else                  retire = 1'b1;
        end else begin
          load_sum   = 1'b1;
          last       = 1'b1;
          retire     = 1'b1;
          phase_next = 1'b0;
        end
      end
    end
  end

  assign pop = retire;

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
      phase     <= 1'b0;
      for (int i = 0; i < NUM_SLOTS; i++) store[i] <= '0;
    end else begin
      phase <= phase_next;
      if (retire) begin
        for (int i = 0; i < NUM_SLOTS; i++) store[i] <= store_next[i];
      end
      if (load)              res_valid <= 1'b1;
      else if (result.ready) res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      result.kind           <= load_sum ? KIND_SUMMARY : head_cmd.kind;
      result.char_index     <= load_sum ? 5'd0 : head_cmd.char_index;
      result.char_value     <= load_sum ? 8'd0 : head_cmd.data;
      result.uav_latitude   <= load_sum ? store_next[SLOT_UAV_LAT] : '0;
      result.uav_longitude  <= load_sum ? store_next[SLOT_UAV_LON] : '0;
      result.sea_level_alt  <= load_sum ? store_next[SLOT_ALT_MSL][15:0] : '0;
      result.ground_height  <= load_sum ? store_next[SLOT_HEIGHT][15:0] : '0;
      result.home_latitude  <= load_sum ? store_next[SLOT_BASE_LAT] : '0;
      result.home_longitude <= load_sum ? store_next[SLOT_BASE_LON] : '0;
      result.ground_speed   <= load_sum ? store_next[SLOT_SPEED][7:0] : '0;
      result.course_heading <= load_sum ? store_next[SLOT_HEADING][15:0] : '0;
      result.last_of_run    <= last;
    end
  end

  assign result.valid = res_valid;

  `DTP_ASSERT_IMPLIES(a_phase_has_head, clk, rst, phase, head_valid && head_cmd.has_sum)
  `DTP_ASSERT_IMPLIES(a_summary_last, clk, rst, result.valid && result.kind == KIND_SUMMARY,
    result.last_of_run)

endmodule

FILE: rtl/drone_id_tlv_beacon_parser.sv
// ----------------------------------------------------------------------------
// drone_id_tlv_beacon_parser
// An accepted byte with a visible effect is written into the command queue and then
// loaded into the output register before its first result is valid.
// Throughput: one byte per cycle while the command queue is not full; a byte
// with a character and a summary holds the output register for both items.
// Reset: synchronous, clears frame tracking, queue, field stores and output.
// ----------------------------------------------------------------------------
//
// Structure:
//   dtp_front  - tracks byte position, frame length and TLV record phase.
//                Each byte with a visible effect becomes one command: frame
//                clear, field clear or byte write, identifier character,
//                summary request.
//   dtp_queue  - QUEUE_DEPTH (default 4) commands deep, so the front keeps taking bytes while
//                the output side is stalled.
//   dtp_back   - owns the field stores, applies updates in command order,
//                and drives the registered result channel. A summary sees
//                the stores with its own byte's update applied.
//
// Bytes after the frame end and header bytes produce no command unless they
// start a frame or are its last byte.

module drone_id_tlv_beacon_parser import dtp_pkg::*; #(
  parameter int ID_CHARS    = 20,
  parameter int QUEUE_DEPTH = 4
) (
  input  logic         clk,
  input  logic         rst,
  dtp_byte_if.sink     beacon,
  dtp_result_if.source result
);

  logic     push, pop, q_full, q_empty;
  dtp_cmd_t push_cmd, head_cmd;

  dtp_front #(
    .ID_CHARS (ID_CHARS)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .beacon   (beacon),
    .q_full   (q_full),
    .push     (push),
    .push_cmd (push_cmd)
  );

  dtp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (q_full),
    .pop      (pop),
    .head_cmd (head_cmd),
    .empty    (q_empty)
  );

  dtp_back u_back (
    .clk      (clk),
    .rst      (rst),
    .head_cmd (head_cmd),
    .q_empty  (q_empty),
    .pop      (pop),
    .result   (result)
  );

endmodule
